// File: sv/hse_pkg.sv
package hse_pkg;

  localparam int unsigned FrameLen = 11;
  localparam int unsigned CodeLen  = 15;
  localparam int unsigned ByteLen  = 8;
  localparam int unsigned MaxRes   = 3;

  // Codeword positions (1-based) that take the frame's data bits, in arrival order
  localparam logic [3:0] DATA_POS [FrameLen] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  // Coverage masks of the four parity bits, bit i stands for position i
  localparam logic [15:0] PAR_MASK [4] = '{
    16'hAAAA, 16'hCCCC, 16'hF0F0, 16'hFF00
  };

  typedef logic [7:0] byte_t;

  // Result bundle handed from the encoder to the output buffer
  typedef struct packed {
    logic [1:0]               cnt;
    logic [MaxRes-1:0][7:0]   bytes;
    logic [MaxRes-1:0]        lasts;
  } res_t;

  // Hamming (15,11) encode; result MSB is position 1, LSB position 15
  function automatic logic [CodeLen-1:0] hamming_encode(input logic [FrameLen-1:0] frame);
    logic [15:0]          cw;
    logic [CodeLen-1:0]   code;
    logic [3:0]           par;
    cw = '0;
    for (int i = 0; i < FrameLen; i++) begin
      cw[DATA_POS[i]] = frame[FrameLen-1-i];
    end
    for (int k = 0; k < 4; k++) begin
      par[k] = ^(cw & PAR_MASK[k]);
    end
    cw[1] = par[0];
    cw[2] = par[1];
    cw[4] = par[2];
    cw[8] = par[3];
    for (int i = 1; i <= CodeLen; i++) begin
      code[CodeLen-i] = cw[i];
    end
    return code;
  endfunction

endpackage

// File: sv/hse_if.sv
// Input byte channel
interface hse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in;

  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

// Encoded byte channel
interface hse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_out;

  modport source (output valid, output code_byte, output last_out, input ready);
  modport sink   (input valid, input code_byte, input last_out, output ready);
endinterface

// File: sv/hse_core.sv
module hse_core (
  input  logic          clk,
  input  logic          rst_n,
  hse_in_if.sink        in_chan,
  input  logic          take,
  output hse_pkg::res_t res,
  output logic          res_vld
);
  import hse_pkg::*;

  // Input register
  logic        a_vld_r;
  logic [7:0]  a_byte_r;
  logic        a_last_r;

  // Stream state
  logic [10:0] frame_bits_r, frame_bits_nxt;
  logic [3:0]  frame_fill_r, frame_fill_nxt;
  logic [6:0]  pack_bits_r,  pack_bits_nxt;
  logic [2:0]  pack_fill_r,  pack_fill_nxt;

  logic [18:0] wide;
  logic        frame_done;
  logic [3:0]  frame_sh;
  logic [10:0] frame;
  logic [14:0] code;
  logic [21:0] acc;
  logic [21:0] acc_al;
  logic [1:0]  n_code;
  logic [7:0]  flush_byte;
  res_t        res_c;

  assign in_chan.ready = !a_vld_r || take;
  assign res_vld       = a_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      a_vld_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      a_byte_r <= in_chan.data_byte;
      a_last_r <= in_chan.last_in;
    end
  end

  // Frame assembly: at most one frame completes per byte
  assign wide       = {frame_bits_r, a_byte_r};
  assign frame_done = (frame_fill_r >= 4'd3);
  assign frame_sh   = frame_fill_r - 4'd3;
  assign frame      = 11'(wide >> frame_sh);
  assign code       = hamming_encode(frame);

  // Byte packing of the new codeword behind the pending bits
  assign acc    = {pack_bits_r, code};
  assign acc_al = 22'(acc << (3'd7 - pack_fill_r));

  always_comb begin
    frame_bits_nxt = wide[10:0];
    frame_fill_nxt = frame_done ? frame_fill_r - 4'd3 : frame_fill_r + 4'd8;
    pack_bits_nxt  = pack_bits_r;
    pack_fill_nxt  = pack_fill_r;
    n_code         = 2'd0;
    res_c          = '0;
    if (frame_done) begin
      pack_bits_nxt  = acc[6:0];
      res_c.bytes[0] = acc_al[21:14];
      res_c.bytes[1] = acc_al[13:6];
      if (pack_fill_r == 3'd0) begin
        n_code        = 2'd1;
        pack_fill_nxt = 3'd7;
      end else begin
        n_code        = 2'd2;
        pack_fill_nxt = pack_fill_r - 3'd1;
      end
    end
    res_c.cnt  = n_code;
    flush_byte = 8'({pack_bits_nxt, 1'b0} << (3'd7 - pack_fill_nxt));
    // End of stream: flush partial byte or tag the final one, then clear state
    if (a_last_r) begin
      if (pack_fill_nxt != 3'd0) begin
        res_c.bytes[n_code] = flush_byte;
        res_c.lasts[n_code] = 1'b1;
        res_c.cnt           = n_code + 2'd1;
      end else if (n_code != 2'd0) begin
        res_c.lasts[n_code - 2'd1] = 1'b1;
      end
      frame_bits_nxt = '0;
      frame_fill_nxt = '0;
      pack_bits_nxt  = '0;
      pack_fill_nxt  = '0;
    end
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r <= '0;
      frame_fill_r <= '0;
      pack_bits_r  <= '0;
      pack_fill_r  <= '0;
    end else if (take) begin
      frame_bits_r <= frame_bits_nxt;
      frame_fill_r <= frame_fill_nxt;
      pack_bits_r  <= pack_bits_nxt;
      pack_fill_r  <= pack_fill_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_fill_r < 4'd11)
    else $error("frame fill out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && a_last_r) |=> (frame_fill_r == 4'd0 && pack_fill_r == 3'd0))
    else $error("state not cleared after end of stream");

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> a_vld_r)
    else $error("result taken without a held request");
`endif

endmodule

// File: sv/hse_obuf.sv
module hse_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  hse_pkg::res_t res,
  input  logic          res_vld,
  output logic          take,
  hse_out_if.source     out_chan
);
  import hse_pkg::*;

  logic [MaxRes-1:0][7:0] slot_byte_r;
  logic [MaxRes-1:0]      slot_last_r;
  logic [1:0]             cnt_r;
  logic                   pop;

  assign out_chan.valid     = (cnt_r != 2'd0);
  assign out_chan.code_byte = slot_byte_r[0];
  assign out_chan.last_out  = slot_last_r[0];
  assign pop                = out_chan.valid && out_chan.ready;

  // Load the next bundle when the buffer is empty or empties in this cycle
  assign take = res_vld && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
    if (take) begin
      slot_byte_r <= res.bytes;
      slot_last_r <= res.lasts;
    end else if (pop) begin
      slot_byte_r <= {8'd0, slot_byte_r[MaxRes-1:1]};
      slot_last_r <= {1'b0, slot_last_r[MaxRes-1:1]};
    end
  end

`ifndef SYNTHESIS
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> cnt_r == $past(res.cnt))
    else $error("buffer count does not match loaded bundle");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !take) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("buffer count not decremented on pop");

  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_out) |-> cnt_r == 2'd1)
    else $error("last byte is not the final buffered byte");
`endif

endmodule

// File: sv/hamming_15_11_byte_stream_encoder.sv
// Hamming (15,11) byte-stream encoder.
// in_chan carries raw bytes (data_byte, MSB first) with last_in on the final
// byte of a stream; out_chan carries packed codeword bytes (earliest bit in
// the MSB) with last_out on the final byte. Both use valid/ready; a request
// moves when valid and ready are high at a rising edge.
// Every 11 input bits make one 15-bit codeword. A request yields 0 to 3
// output bytes: up to two from a finished codeword, plus a zero-padded
// partial byte at end of stream. Trailing bits short of a frame are dropped.
// The first output byte of a request passes the input register and is then
// loaded into the output buffer, which offers it on out_chan. The output
// buffer sends one byte per cycle while out ready is high; a request yielding
// N bytes holds the input until its last one leaves. 15 bits go out per 11 in.
// The input register takes a new request in the cycle the output buffer loads
// the previous one's bytes; with the receiver stalled the block holds one
// request in the input register and one set of bytes in the output buffer.
// Reset (rst_n low, synchronous) empties both registers and starts a new
// stream. When out ready is low the current byte holds and input backs up.
module hamming_15_11_byte_stream_encoder (
  input  logic      clk,
  input  logic      rst_n,
  hse_in_if.sink    in_chan,
  hse_out_if.source out_chan
);
  import hse_pkg::*;

  res_t res;
  logic res_vld;
  logic take;

  hse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .res     (res),
    .res_vld (res_vld)
  );

  hse_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .res_vld  (res_vld),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule
